// ===== design/cgnq_pkg.sv =====
// Shared types, codes and field widths for the graph neighbour query block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package cgnq_pkg;

  localparam int CGNQ_MAX_VERTICES = 32;
  localparam int CGNQ_MAX_EDGES    = 32;

  // Field widths of the request, response and configuration beats
  localparam int REQ_W      = 2;
  localparam int SEL_W      = 3;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 6;
  localparam int VTX_W      = 6;
  localparam int MODE_W     = 2;
  localparam int ITEM_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Stored word widths: edge tables hold ids, start tables hold offsets
  localparam int EID_W = 5;
  localparam int OFS_W = 6;

  localparam int MODE_OUT_BIT = 0;
  localparam int MODE_IN_BIT  = 1;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALL  = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE    = 2'd0,
    REQ_NEIGHBOR = 2'd1,
    REQ_EDGE     = 2'd2
  } req_t;

  typedef enum logic [SEL_W-1:0] {
    TBL_SOURCE    = 3'd0,
    TBL_TARGET    = 3'd1,
    TBL_OUT_ORDER = 3'd2,
    TBL_IN_ORDER  = 3'd3,
    TBL_OUT_START = 3'd4,
    TBL_IN_START  = 3'd5
  } table_sel_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ITEM  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_MODE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT = 1'd0,
    REG_IS_DIRECTED  = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_LO,
    S_HI,
    S_BND,
    S_ORD,
    S_END,
    S_CMP,
    S_DUP,
    S_EMPTY
  } state_t;

endpackage

`default_nettype wire

// ===== design/cgnq_if.sv =====
// Channel interfaces of the graph neighbour query block: request, response
// and configuration write. Depends on cgnq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cgnq_in_if;
  import cgnq_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SEL_W-1:0]  table_select;
  logic [IDX_W-1:0]  table_index;
  logic [VAL_W-1:0]  table_value;
  logic [VTX_W-1:0]  query_vertex;
  logic [MODE_W-1:0] query_mode;

  modport source (output valid, req_type, table_select, table_index, table_value,
                  query_vertex, query_mode, input ready);
  modport sink   (input valid, req_type, table_select, table_index, table_value,
                  query_vertex, query_mode, output ready);
endinterface

interface cgnq_out_if;
  import cgnq_pkg::*;
  logic                valid;
  logic                ready;
  logic [ITEM_W-1:0]   item_value;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, item_value, status, last, input ready);
  modport sink   (input valid, item_value, status, last, output ready);
endinterface

interface cgnq_cfg_if;
  import cgnq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/csr_graph_neighbor_query.sv =====
// Top level of the graph neighbour query block: table memories, query sequencer
// and response register. Depends on cgnq_pkg and the channel interfaces.
//
// The graph lives in six synchronous tables with a registered read port that are
// loaded by write beats; a write gives no response. Table contents are undefined
// until written, so there is no clearing pass after reset. A query first fetches
// the start offsets of the vertex in states S_LO, S_HI and S_BND (two reads of each
// start table), then walks the edge lists: an incident edge query reads the order
// table and then emits each result (S_ORD, S_END), a neighbour query reads the order
// table, then the endpoint table, then emits (S_ORD, S_END, S_CMP), and an equal id
// pair in a directed all-mode merge sends its second beat from an extra state,
// S_DUP. Bad vertex, bad mode and empty list queries give a single beat. One query
// is in flight at a time; the response register lets the next request be taken
// while the final beat of the previous one still waits, and a stalled response
// holds the walk.
`timescale 1ns / 1ps
`default_nettype none

module csr_graph_neighbor_query #(
  parameter int MAX_VERTICES = cgnq_pkg::CGNQ_MAX_VERTICES,
  parameter int MAX_EDGES    = cgnq_pkg::CGNQ_MAX_EDGES
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cgnq_in_if.sink    req,
  cgnq_out_if.source rsp,
  cgnq_cfg_if.sink   cfg
);
  import cgnq_pkg::*;

  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SDEPTH = MAX_VERTICES + 1;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int PW     = $clog2(MAX_EDGES + 1);
  localparam logic [OFS_W-1:0] EDGE_LIMIT = OFS_W'(MAX_EDGES);
  localparam logic [EID_W:0]   EID_LIMIT  = (EID_W+1)'(MAX_EDGES);

  // Configuration registers
  logic [VTX_W-1:0] vertex_count;
  logic             is_directed;

  // Table memories
  logic [EID_W-1:0] src_mem     [MAX_EDGES];
  logic [EID_W-1:0] tgt_mem     [MAX_EDGES];
  logic [EID_W-1:0] out_ord_mem [MAX_EDGES];
  logic [EID_W-1:0] in_ord_mem  [MAX_EDGES];
  logic [OFS_W-1:0] out_st_mem  [SDEPTH];
  logic [OFS_W-1:0] in_st_mem   [SDEPTH];

  logic [EID_W-1:0] src_q, tgt_q, out_ord_q, in_ord_q;
  logic [OFS_W-1:0] out_st_q, in_st_q;

  // Query context
  state_t           state, state_next;
  req_t             req_q;
  logic [VTX_W-1:0] vtx;
  logic [MODE_W-1:0] mode;
  status_t          err_status;
  logic [OFS_W-1:0] out_lo_raw, in_lo_raw;
  logic [PW-1:0]    op, ohi, ip, ihi;
  logic [ITEM_W-1:0] dup_val;

  // Response register
  logic              rsp_valid;
  logic [ITEM_W-1:0] rsp_item;
  status_t           rsp_status;
  logic              rsp_last;

  // Combinational control
  logic              req_acc, wr_acc, qry_acc, bad_vertex;
  logic [31:0]       widx_ext, vlo_ext, vhi_ext;
  logic [EAW-1:0]    wr_eaddr;
  logic [SAW-1:0]    wr_saddr, st_raddr;
  logic [EAW-1:0]    out_ord_raddr, in_ord_raddr, tgt_raddr, src_raddr;
  logic              wr_edge_ok, wr_start_ok;
  logic              out_avail, in_avail, merge, tgt_ok, src_ok;
  logic [PW-1:0]     rem_out, rem_in;
  logic [PW:0]       rem;
  logic [ITEM_W-1:0] val_a, val_b;
  logic              take_out, dup_pair;
  logic              rsp_free, emit_en, emit_last, adv_out, adv_in;
  logic [ITEM_W-1:0] emit_item;
  status_t           emit_status;
  logic [OFS_W-1:0]  out_hi_b, in_hi_b, out_lo_b, in_lo_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      is_directed  <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_VERTEX_COUNT: vertex_count <= cfg.data[VTX_W-1:0];
        REG_IS_DIRECTED:  is_directed  <= cfg.data[0];
      endcase
    end
  end

  // Write decode
  assign req_acc     = req.valid && req.ready;
  assign wr_acc      = req_acc && (req.req_type == REQ_WRITE);
  assign qry_acc     = req_acc && (req.req_type == REQ_NEIGHBOR || req.req_type == REQ_EDGE);
  assign widx_ext    = 32'(req.table_index);
  assign wr_eaddr    = widx_ext[EAW-1:0];
  assign wr_saddr    = widx_ext[SAW-1:0];
  assign wr_edge_ok  = widx_ext < 32'(MAX_EDGES);
  assign wr_start_ok = widx_ext < 32'(SDEPTH);
  assign bad_vertex  = (req.query_vertex >= vertex_count) ||
                       (32'(req.query_vertex) >= 32'(MAX_VERTICES));

  // Read addresses
  assign vlo_ext  = 32'(vtx);
  assign vhi_ext  = 32'(vtx) + 32'd1;
  assign st_raddr = (state == S_HI) ? vhi_ext[SAW-1:0] : vlo_ext[SAW-1:0];

  assign out_avail     = op < ohi;
  assign in_avail      = ip < ihi;
  assign out_ord_raddr = out_avail ? op[EAW-1:0] : '0;
  assign in_ord_raddr  = in_avail ? ip[EAW-1:0] : '0;
  assign tgt_ok        = {1'b0, out_ord_q} < EID_LIMIT;
  assign src_ok        = {1'b0, in_ord_q} < EID_LIMIT;
  assign tgt_raddr     = tgt_ok ? out_ord_q[EAW-1:0] : '0;
  assign src_raddr     = src_ok ? in_ord_q[EAW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_acc && wr_edge_ok) begin
      case (req.table_select)
        TBL_SOURCE:    src_mem[wr_eaddr]     <= req.table_value[EID_W-1:0];
        TBL_TARGET:    tgt_mem[wr_eaddr]     <= req.table_value[EID_W-1:0];
        TBL_OUT_ORDER: out_ord_mem[wr_eaddr] <= req.table_value[EID_W-1:0];
        TBL_IN_ORDER:  in_ord_mem[wr_eaddr]  <= req.table_value[EID_W-1:0];
        default: ;
      endcase
    end
    src_q     <= src_mem[src_raddr];
    tgt_q     <= tgt_mem[tgt_raddr];
    out_ord_q <= out_ord_mem[out_ord_raddr];
    in_ord_q  <= in_ord_mem[in_ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_acc && wr_start_ok) begin
      case (req.table_select)
        TBL_OUT_START: out_st_mem[wr_saddr] <= req.table_value;
        TBL_IN_START:  in_st_mem[wr_saddr]  <= req.table_value;
        default: ;
      endcase
    end
    out_st_q <= out_st_mem[st_raddr];
    in_st_q  <= in_st_mem[st_raddr];
  end

  // Group bounds: clamp the end to the edge tables, pull the start down to the end
  assign out_hi_b = (out_st_q > EDGE_LIMIT) ? EDGE_LIMIT : out_st_q;
  assign in_hi_b  = (in_st_q > EDGE_LIMIT) ? EDGE_LIMIT : in_st_q;
  assign out_lo_b = (out_lo_raw > out_hi_b) ? out_hi_b : out_lo_raw;
  assign in_lo_b  = (in_lo_raw > in_hi_b) ? in_hi_b : in_lo_raw;

  // Walk selection
  assign rem_out  = ohi - op;
  assign rem_in   = ihi - ip;
  assign rem      = {1'b0, rem_out} + {1'b0, rem_in};
  assign merge    = (req_q == REQ_NEIGHBOR) && (mode == MODE_ALL) && is_directed;
  assign val_a    = (req_q == REQ_EDGE) ? out_ord_q : (tgt_ok ? tgt_q : '0);
  assign val_b    = (req_q == REQ_EDGE) ? in_ord_q : (src_ok ? src_q : '0);
  assign dup_pair = merge && out_avail && in_avail && (val_a == val_b);
  assign take_out = (merge && out_avail && in_avail) ? (val_a <= val_b) : out_avail;
  assign rsp_free = !rsp_valid || rsp.ready;

  // Outputs of the sequencer
  always_comb begin
    req.ready   = (state == S_IDLE);
    emit_en     = 1'b0;
    emit_item   = '0;
    emit_status = STAT_ITEM;
    emit_last   = 1'b0;
    adv_out     = 1'b0;
    adv_in      = 1'b0;
    unique case (state)
      S_ERR: begin
        emit_en     = rsp_free;
        emit_status = err_status;
        emit_last   = 1'b1;
      end
      S_EMPTY: begin
        emit_en     = rsp_free;
        emit_status = STAT_EMPTY;
        emit_last   = 1'b1;
      end
      S_END, S_CMP: begin
        if ((state == S_END) == (req_q == REQ_EDGE)) begin
          emit_en   = rsp_free;
          emit_item = take_out ? val_a : val_b;
          emit_last = (rem == (PW+1)'(1));
          adv_out   = rsp_free && take_out;
          adv_in    = rsp_free && !take_out;
        end
      end
      S_DUP: begin
        emit_en   = rsp_free;
        emit_item = dup_val;
        emit_last = (rem == (PW+1)'(1));
        adv_in    = rsp_free;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (qry_acc) begin
          if (bad_vertex || req.query_mode == MODE_NONE) state_next = S_ERR;
          else                                           state_next = S_LO;
        end
      end
      S_ERR, S_EMPTY: if (rsp_free) state_next = S_IDLE;
      S_LO:  state_next = S_HI;
      S_HI:  state_next = S_BND;
      S_BND: state_next = S_ORD;
      S_ORD: state_next = (rem == '0) ? S_EMPTY : S_END;
      S_END: begin
        if (req_q == REQ_NEIGHBOR)    state_next = S_CMP;
        else if (rsp_free)            state_next = emit_last ? S_IDLE : S_ORD;
      end
      S_CMP: begin
        if (rsp_free) begin
          if (dup_pair)       state_next = S_DUP;
          else if (emit_last) state_next = S_IDLE;
          else                state_next = S_ORD;
        end
      end
      S_DUP: if (rsp_free) state_next = emit_last ? S_IDLE : S_ORD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Query context and walk pointers
  always_ff @(posedge clk) begin
    if (qry_acc) begin
      req_q      <= req_t'(req.req_type);
      vtx        <= req.query_vertex;
      mode       <= is_directed ? req.query_mode : MODE_ALL;
      err_status <= bad_vertex ? STAT_RANGE : STAT_MODE;
    end
    if (state == S_HI) begin
      out_lo_raw <= out_st_q;
      in_lo_raw  <= in_st_q;
    end
    if (state == S_BND) begin
      op  <= out_lo_b[PW-1:0];
      ip  <= in_lo_b[PW-1:0];
      ohi <= mode[MODE_OUT_BIT] ? out_hi_b[PW-1:0] : out_lo_b[PW-1:0];
      ihi <= mode[MODE_IN_BIT] ? in_hi_b[PW-1:0] : in_lo_b[PW-1:0];
    end else begin
      // hold the in side of an equal pair until its second beat goes out
      if (adv_out) op <= op + PW'(1);
      if (adv_in && !(state == S_CMP && dup_pair)) ip <= ip + PW'(1);
    end
    if (state == S_CMP) dup_val <= val_b;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst)            rsp_valid <= 1'b0;
    else if (emit_en)   rsp_valid <= 1'b1;
    else if (rsp.ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      rsp_item   <= emit_item;
      rsp_status <= emit_status;
      rsp_last   <= emit_last && !(state == S_CMP && dup_pair);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.item_value = rsp_item;
  assign rsp.status     = rsp_status;
  assign rsp.last       = rsp_last;

endmodule

`default_nettype wire

// ===== test/cgnq_response_checker.sv =====
// Response checker for the graph neighbour query block: mirrors the tables and
// registers, predicts every response beat and compares it with the DUT output.
// Depends on cgnq_pkg and the channel interfaces.
`timescale 1ns / 1ps

module cgnq_response_checker
  import cgnq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cgnq_in_if   req,
  cgnq_out_if  rsp,
  cgnq_cfg_if  cfg,
  output int   fail_count,
  output int   pending_beats,
  output int   beats_checked
);

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    status_t           status;
    logic              last;
  } nbr_beat_t;

  logic [EID_W-1:0] src_tab [CGNQ_MAX_EDGES];
  logic [EID_W-1:0] tgt_tab [CGNQ_MAX_EDGES];
  logic [EID_W-1:0] out_ord [CGNQ_MAX_EDGES];
  logic [EID_W-1:0] in_ord  [CGNQ_MAX_EDGES];
  logic [OFS_W-1:0] out_ofs [CGNQ_MAX_VERTICES+1];
  logic [OFS_W-1:0] in_ofs  [CGNQ_MAX_VERTICES+1];

  logic [CFG_DATA_W-1:0] vcount;
  logic                  directed;

  nbr_beat_t expected_beats[$];
  int failures = 0;
  int beats    = 0;

  // Clamp the group end to the edge tables; a start above the end gives nothing
  function automatic void group_bounds(input logic [OFS_W-1:0] first,
                                       input logic [OFS_W-1:0] stop,
                                       output int lo, output int hi);
    hi = (int'(stop) > CGNQ_MAX_EDGES) ? CGNQ_MAX_EDGES : int'(stop);
    lo = (int'(first) > hi) ? hi : int'(first);
  endfunction

  function automatic void predict_beats(input logic [REQ_W-1:0] rtype,
                                        input logic [VTX_W-1:0] vtx,
                                        input logic [MODE_W-1:0] mode_in);
    nbr_beat_t batch[$];
    nbr_beat_t tail;
    logic [MODE_W-1:0] mode;
    logic [EID_W-1:0] a, b;
    int olo, ohi, ilo, ihi;
    mode = mode_in;
    if (vtx >= vcount || vtx >= CGNQ_MAX_VERTICES) begin
      batch.push_back('{item: '0, status: STAT_RANGE, last: 1'b0});
    end else if (mode == MODE_NONE) begin
      batch.push_back('{item: '0, status: STAT_MODE, last: 1'b0});
    end else begin
      if (!directed) mode = MODE_ALL;
      group_bounds(out_ofs[vtx], out_ofs[int'(vtx) + 1], olo, ohi);
      group_bounds(in_ofs[vtx], in_ofs[int'(vtx) + 1], ilo, ihi);
      if (!mode[MODE_OUT_BIT]) ohi = olo;
      if (!mode[MODE_IN_BIT]) ihi = ilo;
      if (rtype == REQ_EDGE) begin
        for (int i = olo; i < ohi; i++)
          batch.push_back('{item: out_ord[i], status: STAT_ITEM, last: 1'b0});
        for (int i = ilo; i < ihi; i++)
          batch.push_back('{item: in_ord[i], status: STAT_ITEM, last: 1'b0});
      end else if (mode == MODE_ALL && directed) begin
        // merge by id; an id on both sides goes out twice, out side first
        while (olo < ohi && ilo < ihi) begin
          a = tgt_tab[out_ord[olo]];
          b = src_tab[in_ord[ilo]];
          if (a == b) begin
            batch.push_back('{item: a, status: STAT_ITEM, last: 1'b0});
            batch.push_back('{item: b, status: STAT_ITEM, last: 1'b0});
            olo++;
            ilo++;
          end else if (a < b) begin
            batch.push_back('{item: a, status: STAT_ITEM, last: 1'b0});
            olo++;
          end else begin
            batch.push_back('{item: b, status: STAT_ITEM, last: 1'b0});
            ilo++;
          end
        end
        for (; olo < ohi; olo++)
          batch.push_back('{item: tgt_tab[out_ord[olo]], status: STAT_ITEM, last: 1'b0});
        for (; ilo < ihi; ilo++)
          batch.push_back('{item: src_tab[in_ord[ilo]], status: STAT_ITEM, last: 1'b0});
      end else begin
        for (int i = olo; i < ohi; i++)
          batch.push_back('{item: tgt_tab[out_ord[i]], status: STAT_ITEM, last: 1'b0});
        for (int i = ilo; i < ihi; i++)
          batch.push_back('{item: src_tab[in_ord[i]], status: STAT_ITEM, last: 1'b0});
      end
      if (batch.size() == 0)
        batch.push_back('{item: '0, status: STAT_EMPTY, last: 1'b0});
    end
    while (batch.size() > 64) void'(batch.pop_back());
    tail = batch.pop_back();
    tail.last = 1'b1;
    batch.push_back(tail);
    foreach (batch[i]) expected_beats.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    nbr_beat_t exp_beat;
    if (rst) begin
      vcount   = '0;
      directed = 1'b1;
      expected_beats.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_VERTEX_COUNT: vcount = cfg.data;
          REG_IS_DIRECTED:  directed = cfg.data[0];
          default: ;
        endcase
      end

      // check the response before predicting: a request taken on this edge
      // cannot answer on the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_beats.size() == 0) begin
          failures++;
          $error("unexpected response beat: item_value %0d status %0d last %0b",
                 rsp.item_value, rsp.status, rsp.last);
        end else begin
          exp_beat = expected_beats.pop_front();
          beats++;
          if (rsp.item_value !== exp_beat.item) begin
            failures++;
            $error("item_value: expected %0d, got %0d", exp_beat.item, rsp.item_value);
          end
          if (rsp.status !== exp_beat.status) begin
            failures++;
            $error("status: expected %0d, got %0d", exp_beat.status, rsp.status);
          end
          if (rsp.last !== exp_beat.last) begin
            failures++;
            $error("last: expected %0b, got %0b", exp_beat.last, rsp.last);
          end
        end
      end

      if (req.valid && req.ready) begin
        if (req.req_type == REQ_WRITE) begin
          if (req.table_select <= TBL_IN_ORDER && req.table_index < CGNQ_MAX_EDGES) begin
            case (table_sel_t'(req.table_select))
              TBL_SOURCE:    src_tab[req.table_index] = req.table_value[EID_W-1:0];
              TBL_TARGET:    tgt_tab[req.table_index] = req.table_value[EID_W-1:0];
              TBL_OUT_ORDER: out_ord[req.table_index] = req.table_value[EID_W-1:0];
              default:       in_ord[req.table_index]  = req.table_value[EID_W-1:0];
            endcase
          end else if (req.table_index < CGNQ_MAX_VERTICES + 1) begin
            if (req.table_select == TBL_OUT_START) out_ofs[req.table_index] = req.table_value;
            else if (req.table_select == TBL_IN_START) in_ofs[req.table_index] = req.table_value;
          end
        end else if (req.req_type == REQ_NEIGHBOR || req.req_type == REQ_EDGE) begin
          predict_beats(req.req_type, req.query_vertex, req.query_mode);
        end
      end
    end
    fail_count    <= failures;
    pending_beats <= expected_beats.size();
    beats_checked <= beats;
  end

endmodule

// ===== test/tb_csr_graph_neighbor_query.sv =====
// Testbench top for csr_graph_neighbor_query: clock, reset, graph loading,
// query stimulus and the verdict. Depends on cgnq_pkg, the channel interfaces
// and cgnq_response_checker.
`timescale 1ns / 1ps

module tb_csr_graph_neighbor_query;
  import cgnq_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNKNOWN = 2'd3;
  localparam logic [SEL_W-1:0]  TBL_NONE    = 3'd7;
  localparam logic [MODE_W-1:0] MODE_OUT    = MODE_W'(1 << MODE_OUT_BIT);
  localparam logic [MODE_W-1:0] MODE_IN     = MODE_W'(1 << MODE_IN_BIT);
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  bit   calm         = 1'b0;
  bit   hold_request = 1'b0;
  int   items_sent   = 0;
  int   settings_applied = 0;
  int   fail_count, pending_beats, beats_checked;

  cgnq_in_if  req_ch ();
  cgnq_out_if rsp_ch ();
  cgnq_cfg_if cfg_ch ();

  csr_graph_neighbor_query dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cgnq_response_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .pending_beats (pending_beats),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d response beats outstanding", pending_beats);
    $display("tb_csr_graph_neighbor_query: FAIL");
    $finish;
  end

  // Response side: random back-pressure, one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic send_beat(input logic [REQ_W-1:0] rtype, input logic [SEL_W-1:0] sel,
                           input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                           input logic [VTX_W-1:0] vtx, input logic [MODE_W-1:0] mode);
    while (!calm && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rtype;
    req_ch.table_select <= sel;
    req_ch.table_index  <= idx;
    req_ch.table_value  <= val;
    req_ch.query_vertex <= vtx;
    req_ch.query_mode   <= mode;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic send_write(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
    send_beat(REQ_WRITE, sel, idx, val, VTX_W'($urandom_range(63)), MODE_W'($urandom_range(3)));
  endtask

  task automatic send_query(input logic [REQ_W-1:0] rtype, input logic [VTX_W-1:0] vtx,
                            input logic [MODE_W-1:0] mode);
    send_beat(rtype, SEL_W'($urandom_range(7)), IDX_W'($urandom_range(63)),
              VAL_W'($urandom_range(63)), vtx, mode);
  endtask

  // Drop the request, wait for every expected beat, then let the block settle
  task automatic wait_drained(input int tail);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] vc, input bit dir);
    write_register(REG_VERTEX_COUNT, vc);
    write_register(REG_IS_DIRECTED, {(CFG_DATA_W-1)'($urandom_range(31)), dir});
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Build a well-formed graph over vertices below nv: edges sorted by source,
  // in-order sorted by target, ids shuffled; full also overwrites unused entries
  task automatic load_graph(input bit full, input int nv);
    int edge_keys[$];
    int in_keys[$];
    int perm[CGNQ_MAX_EDGES];
    int n_edges, j, t, src, tgt, below_out, below_in;
    n_edges = ($urandom_range(3) == 0) ? CGNQ_MAX_EDGES : $urandom_range(1, CGNQ_MAX_EDGES);
    for (int k = 0; k < n_edges; k++)
      edge_keys.push_back(($urandom_range(nv - 1) << 5) | $urandom_range(nv - 1));
    edge_keys.sort();
    for (int k = 0; k < CGNQ_MAX_EDGES; k++) perm[k] = k;
    for (int k = n_edges - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    for (int k = 0; k < n_edges; k++) begin
      src = edge_keys[k] >> 5;
      tgt = edge_keys[k] & 31;
      // the top value bit is cut off by the edge tables
      send_write(TBL_SOURCE, IDX_W'(perm[k]), {1'($urandom_range(1)), 5'(src)});
      send_write(TBL_TARGET, IDX_W'(perm[k]), {1'($urandom_range(1)), 5'(tgt)});
      send_write(TBL_OUT_ORDER, IDX_W'(k), {1'($urandom_range(1)), 5'(perm[k])});
      in_keys.push_back((tgt << 10) | (src << 5) | k);
    end
    in_keys.sort();
    for (int k = 0; k < n_edges; k++)
      send_write(TBL_IN_ORDER, IDX_W'(k), {1'($urandom_range(1)), 5'(perm[in_keys[k] & 31])});
    for (int v = 0; v <= CGNQ_MAX_VERTICES; v++) begin
      below_out = 0;
      below_in  = 0;
      foreach (edge_keys[k]) begin
        if ((edge_keys[k] >> 5) < v) below_out++;
        if ((edge_keys[k] & 31) < v) below_in++;
      end
      send_write(TBL_OUT_START, IDX_W'(v), VAL_W'(below_out));
      send_write(TBL_IN_START, IDX_W'(v), VAL_W'(below_in));
    end
    if (full) begin
      for (int k = n_edges; k < CGNQ_MAX_EDGES; k++) begin
        send_write(TBL_SOURCE, IDX_W'(perm[k]), VAL_W'($urandom_range(63)));
        send_write(TBL_TARGET, IDX_W'(perm[k]), VAL_W'($urandom_range(63)));
        send_write(TBL_OUT_ORDER, IDX_W'(k), VAL_W'($urandom_range(63)));
        send_write(TBL_IN_ORDER, IDX_W'(k), VAL_W'($urandom_range(63)));
      end
    end
  endtask

  // Mostly queries on the loaded vertices; the rest stray writes and junk beats
  task automatic random_items(input int count, input int nv);
    int r;
    logic [VTX_W-1:0]  vtx;
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  rtype;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_write(SEL_W'($urandom_range(7)), IDX_W'($urandom_range(63)),
                   VAL_W'($urandom_range(63)));
      end else if (r < 16) begin
        send_beat(REQ_UNKNOWN, SEL_W'($urandom_range(7)), IDX_W'($urandom_range(63)),
                  VAL_W'($urandom_range(63)), VTX_W'($urandom_range(63)),
                  MODE_W'($urandom_range(3)));
      end else begin
        vtx   = ($urandom_range(9) == 0) ? VTX_W'($urandom_range(63))
                                         : VTX_W'($urandom_range(nv - 1));
        mode  = ($urandom_range(9) == 0) ? MODE_NONE : MODE_W'($urandom_range(1, 3));
        rtype = $urandom_range(1) ? REQ_W'(REQ_EDGE) : REQ_W'(REQ_NEIGHBOR);
        send_query(rtype, vtx, mode);
      end
    end
  endtask

  initial begin
    int vc, nv;
    bit dir;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.table_select <= '0;
    req_ch.table_index  <= '0;
    req_ch.table_value  <= '0;
    req_ch.query_vertex <= '0;
    req_ch.query_mode   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_VERTEX_COUNT;
    cfg_ch.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // vertex count is still zero after reset: every query is out of range
    send_query(REQ_NEIGHBOR, 6'd0, MODE_ALL);
    send_query(REQ_EDGE, 6'd31, MODE_OUT);
    load_graph(1'b1, 6);
    wait_drained(20);
    apply_settings(6'd32, 1'b1);

    send_query(REQ_NEIGHBOR, 6'd0, MODE_NONE);
    send_query(REQ_NEIGHBOR, 6'd0, MODE_OUT);
    send_query(REQ_NEIGHBOR, 6'd0, MODE_IN);
    send_query(REQ_NEIGHBOR, 6'd0, MODE_ALL);
    send_query(REQ_EDGE, 6'd0, MODE_ALL);
    send_query(REQ_EDGE, 6'd0, MODE_OUT);
    send_query(REQ_NEIGHBOR, 6'd31, MODE_ALL);
    send_query(REQ_NEIGHBOR, 6'd32, MODE_ALL);
    send_query(REQ_EDGE, 6'd63, MODE_IN);
    // group end past the edge tables
    send_write(TBL_OUT_START, 6'd32, 6'd63);
    send_query(REQ_NEIGHBOR, 6'd31, MODE_OUT);
    send_query(REQ_EDGE, 6'd31, MODE_ALL);
    // start above end on the out side, zero length on the in side
    send_write(TBL_OUT_START, 6'd3, 6'd20);
    send_write(TBL_OUT_START, 6'd4, 6'd10);
    send_write(TBL_IN_START, 6'd3, 6'd7);
    send_write(TBL_IN_START, 6'd4, 6'd7);
    send_query(REQ_NEIGHBOR, 6'd3, MODE_ALL);
    send_query(REQ_EDGE, 6'd3, MODE_IN);
    // a write whose top value bit is cut off, writes that must leave the tables alone, and an unknown request
    send_write(TBL_OUT_ORDER, 6'd0, 6'd63);
    send_write(TBL_NONE, 6'd5, 6'd9);
    send_write(TBL_SOURCE, 6'd32, 6'd1);
    send_write(TBL_IN_START, 6'd33, 6'd1);
    send_beat(REQ_UNKNOWN, TBL_SOURCE, 6'd0, 6'd0, 6'd0, MODE_ALL);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin vc = 32; dir = 1'b1; nv = 8; end
        1: begin vc = 1;  dir = 1'b0; nv = 1; end
        2: begin vc = 63; dir = 1'b1; nv = 8; end
        3: begin vc = $urandom_range(2, 31); dir = 1'b0; nv = $urandom_range(2, 6); end
        default: begin vc = $urandom_range(0, 32); dir = 1'b1; nv = $urandom_range(2, 6); end
      endcase
      wait_drained(20);
      calm <= (p == 2);
      apply_settings(CFG_DATA_W'(vc), dir);
      // hold the response side long enough for the request side to back up
      if (p == 1) hold_request <= 1'b1;
      random_items(30, nv);
    end
    req_ch.valid <= 1'b0;

    wait_drained(40);
    $display("Covered %0d request beats under %0d register settings; %0d response beats checked.",
             items_sent, settings_applied, beats_checked);
    $display("Included one %0d-cycle response hold-off and a stretch without idling.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("tb_csr_graph_neighbor_query: PASS");
    end else begin
      $display("tb_csr_graph_neighbor_query: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cgnq_pkg.sv
design/cgnq_if.sv
design/csr_graph_neighbor_query.sv
test/cgnq_response_checker.sv
test/tb_csr_graph_neighbor_query.sv
